>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/mlnp_pkg.sv
package mlnp_pkg;

    typedef enum logic [1:0] {
        OP_INS_HEAD = 2'd0,
        OP_INS_TAIL = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LINKED   = 2'd1,
        ST_UNLINKED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FIX
    } t_state;

    typedef enum logic [1:0] {
        FIX_NONE,
        FIX_HEAD,
        FIX_TAIL,
        FIX_UNLINK
    } t_fix;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        t_op        op;
        logic [2:0] lst;
        logic [7:0] node;
        logic       in_pool;
    } t_item;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

>>> hw/rtl/multi_list_node_pool_manager.sv
// Several doubly linked lists kept over one shared pool of nodes.
// Request channel (queue style): drive i_operation, i_list_id and i_node_id
// and raise push; the request is taken at a clock edge where full is low.
// Operations insert a node at a list's head or tail, remove a node from the
// list that owns it, or query a list.
// Result channel: while empty is low the oldest result is on the o_ ports;
// raise pop to take it. Each request gives exactly one result with status,
// the reported list, its head, tail, empty flag and node count.
// A two-entry queue parts the request side from the executor. The executor
// takes each request in turn: it reads the node memories, then updates the
// target node and list registers, then patches the neighbor node and writes
// the result register. The executor starts the next request only once the
// previous result has been taken.
// A result that is not popped holds the executor; requests keep queueing
// until the two-entry queue is full, then full stays high.
// After reset the node memories are cleared one entry a cycle; full is held
// high during that pass.
module multi_list_node_pool_manager #(
    parameter int POOL_NODES = 256,
    parameter int LIST_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_list_id,
    input  logic [7:0] i_node_id,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_status,
    output logic [2:0] o_list_out,
    output logic [7:0] o_head_node,
    output logic [7:0] o_tail_node,
    output logic       o_list_empty,
    output logic [8:0] o_node_count
);

    logic                 q_valid;
    logic                 q_pop;
    mlnp_pkg::t_item      q_item;
    mlnp_pkg::t_back_stat stat;

    // The front classifies requests and queues them.
    mlnp_front #(
        .POOL_NODES(POOL_NODES),
        .LIST_COUNT(LIST_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_list_id   (i_list_id),
        .i_node_id   (i_node_id),
        .i_stat      (stat),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    // The back owns all list and node state and produces the results.
    mlnp_back #(
        .POOL_NODES(POOL_NODES),
        .LIST_COUNT(LIST_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_stat       (stat),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_status     (o_status),
        .o_list_out   (o_list_out),
        .o_head_node  (o_head_node),
        .o_tail_node  (o_tail_node),
        .o_list_empty (o_list_empty),
        .o_node_count (o_node_count)
    );

endmodule

>>> hw/rtl/mlnp_front.sv
module mlnp_front #(
    parameter int POOL_NODES = 256,
    parameter int LIST_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_operation,
    input  logic [2:0]          i_list_id,
    input  logic [7:0]          i_node_id,
    input  mlnp_pkg::t_back_stat i_stat,
    output logic                o_q_valid,
    output mlnp_pkg::t_item     o_q_item,
    input  logic                i_q_pop
);

    localparam int QD = 2;

    mlnp_pkg::t_item r_q [QD];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            accept;
    logic            pop;
    logic [2:0]      lst_mod;
    mlnp_pkg::t_item item;

    // List ids wrap around the number of lists.
    always_comb begin
        lst_mod = i_list_id;
        for (int k = 0; k < 8; k++) begin
            if (32'(lst_mod) >= LIST_COUNT) begin
                lst_mod = lst_mod - 3'(LIST_COUNT);
            end
        end
    end

    always_comb begin
        item.op      = mlnp_pkg::t_op'(i_operation);
        item.lst     = lst_mod;
        item.node    = i_node_id;
        item.in_pool = (32'(i_node_id) < POOL_NODES);
    end

    assign o_full    = (r_cnt == 2'(QD)) || i_stat.clearing;
    assign accept    = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!accept && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

>>> hw/rtl/mlnp_back.sv
module mlnp_back #(
    parameter int POOL_NODES = 256,
    parameter int LIST_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  mlnp_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output mlnp_pkg::t_back_stat o_stat,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [1:0]           o_status,
    output logic [2:0]           o_list_out,
    output logic [7:0]           o_head_node,
    output logic [7:0]           o_tail_node,
    output logic                 o_list_empty,
    output logic [8:0]           o_node_count
);

    localparam int NW = $clog2(POOL_NODES);
    localparam int PW = NW + 1;
    localparam int SW = $clog2(POOL_NODES + 1);
    localparam int OW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam logic [PW-1:0] NIL = {1'b1, {NW{1'b0}}};

    // Node link memories; the top bit of a link word marks the null link.
    logic [PW-1:0] mem_next   [POOL_NODES];
    logic [PW-1:0] mem_prev   [POOL_NODES];
    logic [OW-1:0] mem_owner  [POOL_NODES];
    logic          mem_linked [POOL_NODES];

    logic [NW-1:0] r_head [LIST_COUNT];
    logic [NW-1:0] r_tail [LIST_COUNT];
    logic [SW-1:0] r_size [LIST_COUNT];

    mlnp_pkg::t_state  r_state;
    mlnp_pkg::t_state  n_state;
    logic [NW-1:0]     r_clr;
    mlnp_pkg::t_op     r_op;
    logic [OW-1:0]     r_lst;
    logic [NW-1:0]     r_nd;
    logic              r_in_pool;
    logic [PW-1:0]     r_rd_next;
    logic [PW-1:0]     r_rd_prev;
    logic [OW-1:0]     r_rd_owner;
    logic              r_rd_linked;
    mlnp_pkg::t_status r_st;
    mlnp_pkg::t_status n_st;
    logic [OW-1:0]     r_rep;
    logic [OW-1:0]     n_rep;
    mlnp_pkg::t_fix    r_fix;
    mlnp_pkg::t_fix    n_fix;
    logic [NW-1:0]     r_nb;
    logic [NW-1:0]     n_nb;

    logic              r_res_valid;
    logic [1:0]        r_res_status;
    logic [2:0]        r_res_list;
    logic [7:0]        r_res_head;
    logic [7:0]        r_res_tail;
    logic              r_res_empty;
    logic [8:0]        r_res_count;

    logic              rd_en;
    logic              we_next;
    logic [NW-1:0]     wa_next;
    logic [PW-1:0]     wd_next;
    logic              we_prev;
    logic [NW-1:0]     wa_prev;
    logic [PW-1:0]     wd_prev;
    logic              we_own;
    logic [NW-1:0]     wa_own;
    logic [OW-1:0]     wd_own;
    logic              we_lnk;
    logic [NW-1:0]     wa_lnk;
    logic              wd_lnk;
    logic              list_we;
    logic [OW-1:0]     cl;
    logic [NW-1:0]     nh;
    logic [NW-1:0]     nt;
    logic [SW-1:0]     ns;
    logic              is_ins;
    logic              report;

    assign o_stat.clearing = (r_state == mlnp_pkg::S_CLEAR);
    assign is_ins = (r_op == mlnp_pkg::OP_INS_HEAD) || (r_op == mlnp_pkg::OP_INS_TAIL);
    assign cl     = (r_op == mlnp_pkg::OP_REMOVE) ? r_rd_owner : r_lst;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mlnp_pkg::S_CLEAR: begin
                if (r_clr == NW'(POOL_NODES - 1)) begin
                    n_state = mlnp_pkg::S_IDLE;
                end
            end
            mlnp_pkg::S_IDLE: begin
                if (i_q_valid && !r_res_valid) begin
                    n_state = mlnp_pkg::S_LOOK;
                end
            end
            mlnp_pkg::S_LOOK: n_state = mlnp_pkg::S_FIX;
            mlnp_pkg::S_FIX:  n_state = mlnp_pkg::S_IDLE;
            default:          n_state = mlnp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        o_q_pop = 1'b0;
        we_next = 1'b0;
        wa_next = r_nd;
        wd_next = NIL;
        we_prev = 1'b0;
        wa_prev = r_nd;
        wd_prev = NIL;
        we_own  = 1'b0;
        wa_own  = r_nd;
        wd_own  = r_lst;
        we_lnk  = 1'b0;
        wa_lnk  = r_nd;
        wd_lnk  = 1'b0;
        list_we = 1'b0;
        nh      = r_head[cl];
        nt      = r_tail[cl];
        ns      = r_size[cl];
        n_st    = mlnp_pkg::ST_OK;
        n_rep   = r_lst;
        n_fix   = mlnp_pkg::FIX_NONE;
        n_nb    = r_head[cl];
        report  = 1'b0;
        case (r_state)
            mlnp_pkg::S_CLEAR: begin
                we_next = 1'b1;
                wa_next = r_clr;
                we_prev = 1'b1;
                wa_prev = r_clr;
                we_own  = 1'b1;
                wa_own  = r_clr;
                wd_own  = '0;
                we_lnk  = 1'b1;
                wa_lnk  = r_clr;
            end
            mlnp_pkg::S_IDLE: begin
                if (i_q_valid && !r_res_valid) begin
                    rd_en   = 1'b1;
                    o_q_pop = 1'b1;
                end
            end
            mlnp_pkg::S_LOOK: begin
                if (r_op == mlnp_pkg::OP_QUERY) begin
                    n_rep = r_lst;
                end else if (!r_in_pool) begin
                    n_st  = is_ins ? mlnp_pkg::ST_LINKED : mlnp_pkg::ST_UNLINKED;
                    n_rep = is_ins ? r_lst : '0;
                end else if (is_ins) begin
                    n_rep = r_lst;
                    if (r_rd_linked) begin
                        n_st = mlnp_pkg::ST_LINKED;
                    end else begin
                        we_own  = 1'b1;
                        we_lnk  = 1'b1;
                        wd_lnk  = 1'b1;
                        we_next = 1'b1;
                        we_prev = 1'b1;
                        list_we = 1'b1;
                        ns      = r_size[cl] + SW'(1);
                        if (r_size[cl] == '0) begin
                            nh = r_nd;
                            nt = r_nd;
                        end else if (r_op == mlnp_pkg::OP_INS_HEAD) begin
                            wd_next = {1'b0, r_head[cl]};
                            nh      = r_nd;
                            n_fix   = mlnp_pkg::FIX_HEAD;
                            n_nb    = r_head[cl];
                        end else begin
                            wd_prev = {1'b0, r_tail[cl]};
                            nt      = r_nd;
                            n_fix   = mlnp_pkg::FIX_TAIL;
                            n_nb    = r_tail[cl];
                        end
                    end
                end else begin
                    n_rep = r_rd_owner;
                    if (!r_rd_linked) begin
                        n_st = mlnp_pkg::ST_UNLINKED;
                    end else begin
                        we_next = 1'b1;
                        we_prev = 1'b1;
                        we_lnk  = 1'b1;
                        list_we = 1'b1;
                        ns      = r_size[cl] - SW'(1);
                        n_fix   = mlnp_pkg::FIX_UNLINK;
                        // A node at either end hands that end to its neighbor.
                        if (r_rd_next[NW] && !r_rd_prev[NW]) begin
                            nt = r_rd_prev[NW-1:0];
                        end
                        if (r_rd_prev[NW] && !r_rd_next[NW]) begin
                            nh = r_rd_next[NW-1:0];
                        end
                    end
                end
            end
            mlnp_pkg::S_FIX: begin
                report = 1'b1;
                case (r_fix)
                    mlnp_pkg::FIX_HEAD: begin
                        we_prev = 1'b1;
                        wa_prev = r_nb;
                        wd_prev = {1'b0, r_nd};
                    end
                    mlnp_pkg::FIX_TAIL: begin
                        we_next = 1'b1;
                        wa_next = r_nb;
                        wd_next = {1'b0, r_nd};
                    end
                    mlnp_pkg::FIX_UNLINK: begin
                        we_prev = !r_rd_next[NW];
                        wa_prev = r_rd_next[NW-1:0];
                        wd_prev = r_rd_prev;
                        we_next = !r_rd_prev[NW];
                        wa_next = r_rd_prev[NW-1:0];
                        wd_next = r_rd_next;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlnp_pkg::S_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mlnp_pkg::S_CLEAR) begin
                r_clr <= r_clr + NW'(1);
            end
            if (report) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LIST_COUNT; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_size[i] <= '0;
            end
        end else if (list_we) begin
            r_head[cl] <= nh;
            r_tail[cl] <= nt;
            r_size[cl] <= ns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op      <= i_q_item.op;
            r_lst     <= OW'(i_q_item.lst);
            r_nd      <= NW'(i_q_item.node);
            r_in_pool <= i_q_item.in_pool;
        end
        if (r_state == mlnp_pkg::S_LOOK) begin
            r_st  <= n_st;
            r_rep <= n_rep;
            r_fix <= n_fix;
            r_nb  <= n_nb;
        end
        if (report) begin
            r_res_status <= r_st;
            r_res_list   <= 3'(r_rep);
            r_res_empty  <= (r_size[r_rep] == '0);
            r_res_head   <= (r_size[r_rep] == '0) ? 8'd0 : 8'(r_head[r_rep]);
            r_res_tail   <= (r_size[r_rep] == '0) ? 8'd0 : 8'(r_tail[r_rep]);
            r_res_count  <= 9'(r_size[r_rep]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            mem_next[wa_next] <= wd_next;
        end
        if (rd_en) begin
            r_rd_next <= mem_next[NW'(i_q_item.node)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_prev) begin
            mem_prev[wa_prev] <= wd_prev;
        end
        if (rd_en) begin
            r_rd_prev <= mem_prev[NW'(i_q_item.node)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_own) begin
            mem_owner[wa_own] <= wd_own;
        end
        if (rd_en) begin
            r_rd_owner <= mem_owner[NW'(i_q_item.node)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_lnk) begin
            mem_linked[wa_lnk] <= wd_lnk;
        end
        if (rd_en) begin
            r_rd_linked <= mem_linked[NW'(i_q_item.node)];
        end
    end

    assign o_empty      = !r_res_valid;
    assign o_status     = r_res_status;
    assign o_list_out   = r_res_list;
    assign o_head_node  = r_res_head;
    assign o_tail_node  = r_res_tail;
    assign o_list_empty = r_res_empty;
    assign o_node_count = r_res_count;

endmodule

>>> hw/rtl/mlnp_checker.sv
`include "assert_macros.svh"

module mlnp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_status,
    input logic [7:0] o_head_node,
    input logic [7:0] o_tail_node,
    input logic       o_list_empty,
    input logic [8:0] o_node_count
);

    logic count_zero;
    logic ends_zero;
    logic stall;

    assign count_zero = (o_node_count == 9'd0);
    assign ends_zero  = (o_head_node == 8'd0) && (o_tail_node == 8'd0);
    assign stall      = !empty && !pop;

    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty, "result pending after reset")
    `ASSERT_CLK(a_status_code, i_clk, i_rst_n, !empty |-> (o_status != 2'd3), "bad status")
    `ASSERT_CLK(a_empty_count, i_clk, i_rst_n, !empty |-> (o_list_empty == count_zero), "bad flag")
    `ASSERT_CLK(a_empty_ends, i_clk, i_rst_n, (!empty && o_list_empty) |-> ends_zero, "bad ends")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, stall |=> (!empty && $stable(o_node_count)), "lost result")

endmodule

bind multi_list_node_pool_manager mlnp_checker u_mlnp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_status     (o_status),
    .o_head_node  (o_head_node),
    .o_tail_node  (o_tail_node),
    .o_list_empty (o_list_empty),
    .o_node_count (o_node_count)
);
